FILE: rtl/core/ccsf_pkg.sv
// ----------------------------------------------------------------------------
// ccsf_pkg
// Shared types and constants of the curve shortening flow block.
// ----------------------------------------------------------------------------
package ccsf_pkg;

  localparam int unsigned NUM_COORD = 3;
  localparam int unsigned DIV_STEPS = 35;   // quotient bits per division
  localparam int unsigned SQRT_STEPS = 32;  // root bits

  // register index within the configuration space (paddr[2])
  localparam logic REG_POINT_COUNT = 1'b0;
  localparam logic REG_DIMENSION   = 1'b1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_RD_A    = 14'b00000000000010,
    ST_RD_B    = 14'b00000000000100,
    ST_RD_C    = 14'b00000000001000,
    ST_RD_D    = 14'b00000000010000,
    ST_MAG     = 14'b00000000100000,
    ST_SQ      = 14'b00000001000000,
    ST_SQRT_GO = 14'b00000010000000,
    ST_SQRT_WT = 14'b00000100000000,
    ST_UDIV_GO = 14'b00001000000000,
    ST_UDIV_WT = 14'b00010000000000,
    ST_FDIV_GO = 14'b00100000000000,
    ST_FDIV_WT = 14'b01000000000000,
    ST_OUT     = 14'b10000000000000
  } ccsf_state_e;

endpackage

FILE: rtl/core/ccsf_store.sv
// ----------------------------------------------------------------------------
// ccsf_store
// Vertex store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ccsf_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 96
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ccsf_divider.sv
// ----------------------------------------------------------------------------
// ccsf_divider
// Restoring unsigned divider, one quotient bit per cycle. The dividend must
// stay below divisor * 2^DIV_STEPS.
// ----------------------------------------------------------------------------
module ccsf_divider
  import ccsf_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [65:0]            dividend_i,
  input  logic [33:0]            divisor_i,
  output logic [DIV_STEPS-1:0]   quot_o,
  output logic                   done_o
);

  logic                 run_q;
  logic [5:0]           cnt_q;
  logic                 done_q;
  logic [33:0]          rem_q;
  logic [65:0]          dvd_q;
  logic [33:0]          dvs_q;
  logic [DIV_STEPS-1:0] quot_q;
  logic [34:0]          trial;
  logic                 fits;

  assign trial = {rem_q, dvd_q[DIV_STEPS-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'(DIV_STEPS);
      end else if (run_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= 34'(dividend_i[65:DIV_STEPS]);
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q  <= fits ? 34'(trial - {1'b0, dvs_q}) : trial[33:0];
      dvd_q  <= {dvd_q[64:0], 1'b0};
      quot_q <= {quot_q[DIV_STEPS-2:0], fits};
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

FILE: rtl/core/ccsf_isqrt.sv
// ----------------------------------------------------------------------------
// ccsf_isqrt
// Integer square root of a 64-bit value, one root bit per cycle.
// ----------------------------------------------------------------------------
module ccsf_isqrt
  import ccsf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic [31:0] root_o,
  output logic        done_o
);

  logic        run_q;
  logic [5:0]  cnt_q;
  logic        done_q;
  logic [63:0] x_q;
  logic [63:0] r_q;
  logic [63:0] bit_q;
  logic [64:0] trial;
  logic        fits;

  assign trial = {1'b0, r_q} + {1'b0, bit_q};
  assign fits  = {1'b0, x_q} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'(SQRT_STEPS);
      end else if (run_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= radicand_i;
      r_q   <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (run_q) begin
      if (fits) begin
        x_q <= x_q - trial[63:0];
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_o = r_q[31:0];
  assign done_o = done_q;

endmodule

FILE: rtl/core/closed_curve_shortening_flow_rhs.sv
// ----------------------------------------------------------------------------
// closed_curve_shortening_flow_rhs
// Curvature flow of a closed polygon, Q16.16, with an APB register port.
// ----------------------------------------------------------------------------
// A load item (req_type 0) writes one vertex and busy_o stays low. A query
// item (req_type 1) raises busy_o through a run that ends early when an edge
// has zero length: three store reads, per edge three squarings, a 32-step
// square root and three 35-step divisions for the unit vector, then three
// 35-step divisions for the flow, all on one bit-serial divider and one root
// unit. The result appears on the result ports for exactly one cycle with
// done_o high, the cycle in which busy_o falls; the receiver must take it
// then. A query whose index is not below the clamped point count returns
// nothing. A query must only touch vertices that were loaded.
// ----------------------------------------------------------------------------
module closed_curve_shortening_flow_rhs
  import ccsf_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned MAX_DIM    = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               req_type_i,
  input  logic [9:0]         index_i,
  input  logic signed [31:0] coord_0_i,
  input  logic signed [31:0] coord_1_i,
  input  logic signed [31:0] coord_2_i,
  output logic               done_o,
  output logic [9:0]         vertex_o,
  output logic signed [31:0] flow_0_o,
  output logic signed [31:0] flow_1_o,
  output logic signed [31:0] flow_2_o,
  output logic               degenerate_o,
  output logic               saturated_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned SW = 32 * MAX_DIM;

  ccsf_state_e state_q, state_d;

  logic [10:0] point_count_q;
  logic [1:0]  dimension_q;
  logic [10:0] n_eff;
  logic [1:0]  dim_eff;
  logic [31:0] pc_w, n_w;

  // configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q <= 11'd1024;
      dimension_q   <= 2'd2;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_POINT_COUNT: point_count_q <= pwdata[10:0];
        REG_DIMENSION:   dimension_q   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_POINT_COUNT: prdata = {21'd0, point_count_q};
      REG_DIMENSION:   prdata = {30'd0, dimension_q};
      default:         prdata = '0;
    endcase
  end

  // clamp registers when used
  always_comb begin
    pc_w = 32'(point_count_q);
    if (pc_w < 32'd3) n_w = 32'd3;
    else if (pc_w > 32'(MAX_POINTS)) n_w = 32'(MAX_POINTS);
    else n_w = pc_w;
    n_eff = n_w[10:0];
    if (dimension_q == 2'd0) dim_eff = 2'd1;
    else if (32'(dimension_q) > 32'(MAX_DIM)) dim_eff = 2'(MAX_DIM);
    else dim_eff = dimension_q;
  end

  // vertex store
  logic          accept;
  logic          st_we;
  logic [AW-1:0] st_raddr;
  logic [SW-1:0] st_wdata, st_rdata;
  logic signed [31:0] in_coord [NUM_COORD];
  logic signed [31:0] rd_coord [NUM_COORD];

  assign accept = start_i && !busy_o;
  assign st_we  = accept && (req_type_i == REQ_LOAD) && (32'(index_i) < 32'(MAX_POINTS));
  assign in_coord[0] = coord_0_i;
  assign in_coord[1] = coord_1_i;
  assign in_coord[2] = coord_2_i;

  for (genvar g = 0; g < NUM_COORD; g++) begin : g_coord
    if (g < MAX_DIM) begin : g_used
      assign st_wdata[g*32 +: 32] = in_coord[g];
      assign rd_coord[g] = (2'(g) < dim_eff) ? $signed(st_rdata[g*32 +: 32]) : 32'sd0;
    end else begin : g_unused
      assign rd_coord[g] = 32'sd0;
    end
  end

  ccsf_store #(
    .DEPTH(MAX_POINTS),
    .WIDTH(SW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (AW'(index_i)),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // datapath registers
  logic [9:0]    vtx_q;
  logic [AW-1:0] prv_q, nxt_q;
  logic          edge_q;
  logic [1:0]    j_q;
  logic signed [31:0] pa_q [NUM_COORD];
  logic signed [31:0] pb_q [NUM_COORD];
  logic signed [31:0] pc_q [NUM_COORD];
  logic [31:0]   mag_q [NUM_COORD];
  logic          neg_q [NUM_COORD];
  logic          shift_q, sa_q;
  logic [63:0]   sum_q;
  logic [31:0]   len_q, len_a_q;
  logic signed [33:0] ta_q [NUM_COORD];
  logic signed [33:0] tb_q [NUM_COORD];
  logic          fneg_q;
  logic [31:0]   flow_q [NUM_COORD];
  logic          degen_q, sat_q, done_q;

  logic [10:0]   idx_w, prv_w, nxt_w;
  logic [32:0]   mag_w [NUM_COORD];
  logic          big_w;
  logic [63:0]   sq_w;
  logic [33:0]   la_w;
  logic signed [34:0] fdiff_w;
  logic [34:0]   fmag_w;

  // shared units
  logic                 sqrt_start, sqrt_done;
  logic [31:0]          sqrt_root;
  logic                 div_start, div_done;
  logic [65:0]          div_dividend;
  logic [33:0]          div_divisor;
  logic [DIV_STEPS-1:0] div_quot;

  ccsf_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sum_q),
    .root_o     (sqrt_root),
    .done_o     (sqrt_done)
  );

  ccsf_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  always_comb begin
    idx_w = {1'b0, index_i};
    prv_w = (idx_w == 11'd0) ? n_eff - 11'd1 : idx_w - 11'd1;
    nxt_w = (idx_w + 11'd1 == n_eff) ? 11'd0 : idx_w + 11'd1;

    big_w = 1'b0;
    for (int j = 0; j < NUM_COORD; j++) begin
      logic signed [32:0] d;
      d = edge_q ? (33'(pc_q[j]) - 33'(pb_q[j])) : (33'(pb_q[j]) - 33'(pa_q[j]));
      mag_w[j] = d[32] ? 33'(-d) : 33'(d);
      big_w = big_w | mag_w[j][32] | mag_w[j][31];
    end

    sq_w    = 64'(mag_q[j_q]) * 64'(mag_q[j_q]);
    la_w    = sa_q ? {1'b0, len_a_q, 1'b0} : {2'b00, len_a_q};
    fdiff_w = 35'(tb_q[j_q]) - 35'(ta_q[j_q]);
    fmag_w  = fdiff_w[34] ? 35'(-fdiff_w) : 35'(fdiff_w);

    st_raddr = prv_q;
    if (state_q == ST_RD_B) st_raddr = AW'(vtx_q);
    else if (state_q == ST_RD_C) st_raddr = nxt_q;

    sqrt_start   = (state_q == ST_SQRT_GO);
    div_start    = (state_q == ST_UDIV_GO) || (state_q == ST_FDIV_GO);
    if (state_q == ST_FDIV_GO) begin
      div_dividend = 66'(fmag_w) + 66'(la_w >> 1);
      div_divisor  = la_w;
    end else begin
      div_dividend = {2'b00, mag_q[j_q], 32'd0} + 66'(len_q >> 1);
      div_divisor  = {2'b00, len_q};
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && req_type_i == REQ_QUERY && idx_w < n_eff) state_d = ST_RD_A;
      end
      ST_RD_A:    state_d = ST_RD_B;
      ST_RD_B:    state_d = ST_RD_C;
      ST_RD_C:    state_d = ST_RD_D;
      ST_RD_D:    state_d = ST_MAG;
      ST_MAG:     state_d = ST_SQ;
      ST_SQ:      if (j_q == 2'd2) state_d = ST_SQRT_GO;
      ST_SQRT_GO: state_d = ST_SQRT_WT;
      ST_SQRT_WT: begin
        if (sqrt_done) state_d = (sqrt_root == 32'd0) ? ST_OUT : ST_UDIV_GO;
      end
      ST_UDIV_GO: state_d = ST_UDIV_WT;
      ST_UDIV_WT: begin
        if (div_done) begin
          if (j_q != 2'd2) state_d = ST_UDIV_GO;
          else state_d = edge_q ? ST_FDIV_GO : ST_MAG;
        end
      end
      ST_FDIV_GO: state_d = ST_FDIV_WT;
      ST_FDIV_WT: if (div_done) state_d = (j_q == 2'd2) ? ST_OUT : ST_FDIV_GO;
      ST_OUT:     state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == ST_OUT);
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        vtx_q   <= index_i;
        prv_q   <= AW'(prv_w);
        nxt_q   <= AW'(nxt_w);
        edge_q  <= 1'b0;
        degen_q <= 1'b0;
        sat_q   <= 1'b0;
        for (int j = 0; j < NUM_COORD; j++) flow_q[j] <= '0;
      end
      ST_RD_B: pa_q <= rd_coord;
      ST_RD_C: pb_q <= rd_coord;
      ST_RD_D: pc_q <= rd_coord;
      ST_MAG: begin
        shift_q <= big_w;
        for (int j = 0; j < NUM_COORD; j++) begin
          mag_q[j] <= big_w ? mag_w[j][32:1] : mag_w[j][31:0];
          neg_q[j] <= edge_q ? (pc_q[j] < pb_q[j]) : (pb_q[j] < pa_q[j]);
        end
        sum_q <= '0;
        j_q   <= 2'd0;
      end
      ST_SQ: begin
        sum_q <= sum_q + sq_w;
        j_q   <= j_q + 2'd1;
      end
      ST_SQRT_WT: begin
        if (sqrt_done) begin
          len_q <= sqrt_root;
          j_q   <= 2'd0;
          if (!edge_q) begin
            len_a_q <= sqrt_root;
            sa_q    <= shift_q;
          end
          // zero edge: report degenerate with zero flows
          if (sqrt_root == 32'd0) degen_q <= 1'b1;
        end
      end
      ST_UDIV_WT: begin
        if (div_done) begin
          logic signed [33:0] t;
          t = neg_q[j_q] ? -$signed({1'b0, div_quot[32:0]})
                         : $signed({1'b0, div_quot[32:0]});
          if (edge_q) tb_q[j_q] <= t;
          else ta_q[j_q] <= t;
          if (j_q == 2'd2) begin
            j_q    <= 2'd0;
            edge_q <= 1'b1;
          end else begin
            j_q <= j_q + 2'd1;
          end
        end
      end
      ST_FDIV_GO: fneg_q <= fdiff_w[34];
      ST_FDIV_WT: begin
        if (div_done) begin
          if (fneg_q) begin
            if (div_quot > 35'h0_8000_0000) begin
              flow_q[j_q] <= 32'h8000_0000;
              sat_q       <= 1'b1;
            end else begin
              flow_q[j_q] <= 32'(-div_quot);
            end
          end else begin
            if (div_quot > 35'h0_7FFF_FFFF) begin
              flow_q[j_q] <= 32'h7FFF_FFFF;
              sat_q       <= 1'b1;
            end else begin
              flow_q[j_q] <= div_quot[31:0];
            end
          end
          j_q <= j_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign vertex_o     = vtx_q;
  assign flow_0_o     = flow_q[0];
  assign flow_1_o     = flow_q[1];
  assign flow_2_o     = flow_q[2];
  assign degenerate_o = degen_q;
  assign saturated_o  = sat_q;

  // checks
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && degenerate_o) |->
      (!saturated_o && flow_0_o == 32'sd0 && flow_1_o == 32'sd0 && flow_2_o == 32'sd0))
    else $error("degenerate result carries nonzero flow");

  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy without an accepted item");

  a_one_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sqrt_start && div_start))
    else $error("root and divider started together");

endmodule

FILE: bench/tb_closed_curve_shortening_flow_rhs.sv
// ----------------------------------------------------------------------------
// tb_closed_curve_shortening_flow_rhs
// Self-checking bench for the curvature flow block.
// ----------------------------------------------------------------------------
// Sets polygon size and dimension over the APB port, loads closed polygons
// through the item port, issues queries in random bursts and checks every
// result against a bit-accurate flow predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
module tb_closed_curve_shortening_flow_rhs;
  import ccsf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [9:0]         vertex;
    logic signed [31:0] flow [3];
    logic               degen;
    logic               sat;
  } flow_res_t;

  class flow_scoreboard;
    longint    pts [1024][3];
    bit [10:0] n_reg;
    bit [1:0]  dim_reg;
    flow_res_t pending_q [$];
    int        mismatches;
    bit        failed;

    function new();
      foreach (pts[i, j]) pts[i][j] = 0;
      n_reg = 11'd1024;
      dim_reg = 2'd2;
    endfunction

    function int eff_points();
      if (n_reg < 3) return 3;
      if (n_reg > 1024) return 1024;
      return n_reg;
    endfunction

    function int eff_dim();
      return (dim_reg == 0) ? 1 : dim_reg;
    endfunction

    function bit [63:0] int_sqrt(bit [63:0] x);
      bit [63:0] r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Length of edge a->b in Q16.16 units; unit vector in Q32.
    function bit [63:0] edge_unit(int a, int b, output longint t [3]);
      bit [63:0] mag [3];
      bit        neg [3];
      bit [63:0] big, sum, len, q;
      longint    d;
      int        s;
      big = 0;
      sum = 0;
      for (int j = 0; j < 3; j++) begin
        d = (j < eff_dim()) ? pts[b][j] - pts[a][j] : 0;
        neg[j] = d < 0;
        mag[j] = neg[j] ? -d : d;
        if (mag[j] > big) big = mag[j];
        t[j] = 0;
      end
      s = (big >= 64'h8000_0000) ? 1 : 0;
      for (int j = 0; j < 3; j++) begin
        mag[j] >>= s;
        sum += mag[j] * mag[j];
      end
      len = int_sqrt(sum);
      if (len == 0) return 0;
      for (int j = 0; j < 3; j++) begin
        q = ((mag[j] << 32) + len / 2) / len;
        t[j] = neg[j] ? -longint'(q) : longint'(q);
      end
      return len << s;
    endfunction

    function void write_reg(logic [2:0] addr, logic [31:0] data);
      if (addr[2] == REG_POINT_COUNT) n_reg = data[10:0];
      else dim_reg = data[1:0];
    endfunction

    function void note_item(logic req, logic [9:0] idx, logic signed [31:0] c [3]);
      int        n, prv, nxt;
      longint    ta [3], tb [3], diff;
      bit [63:0] la, lb, m, q;
      flow_res_t e;
      n = eff_points();
      if (req == REQ_LOAD) begin
        for (int j = 0; j < 3; j++) pts[idx][j] = c[j];
        return;
      end
      if (idx >= n) return;
      prv = (idx == 0) ? n - 1 : idx - 1;
      nxt = (idx + 1 == n) ? 0 : idx + 1;
      la = edge_unit(prv, idx, ta);
      lb = edge_unit(idx, nxt, tb);
      e.vertex = idx;
      e.degen = (la == 0) || (lb == 0);
      e.sat = 0;
      for (int j = 0; j < 3; j++) begin
        e.flow[j] = 0;
        if (!e.degen) begin
          diff = tb[j] - ta[j];
          m = (diff < 0) ? -diff : diff;
          q = (m + la / 2) / la;
          if (diff < 0) begin
            if (q > 64'h8000_0000) begin
              q = 64'h8000_0000;
              e.sat = 1;
            end
            e.flow[j] = -longint'(q);
          end else begin
            if (q > 64'h7FFF_FFFF) begin
              q = 64'h7FFF_FFFF;
              e.sat = 1;
            end
            e.flow[j] = q;
          end
        end
      end
      pending_q.push_back(e);
    endfunction

    function void check_result(flow_res_t a);
      flow_res_t e;
      if (pending_q.size() == 0) begin
        failed = 1;
        $display("unexpected result for vertex %0d", a.vertex);
        return;
      end
      e = pending_q.pop_front();
      if (a.vertex !== e.vertex || a.flow[0] !== e.flow[0] || a.flow[1] !== e.flow[1] ||
          a.flow[2] !== e.flow[2] || a.degen !== e.degen || a.sat !== e.sat) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp v=%0d f=%h %h %h dg=%b st=%b, got v=%0d f=%h %h %h dg=%b st=%b",
                   e.vertex, e.flow[0], e.flow[1], e.flow[2], e.degen, e.sat,
                   a.vertex, a.flow[0], a.flow[1], a.flow[2], a.degen, a.sat);
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               start_i = 0;
  logic               busy_o;
  logic               req_type_i = 0;
  logic [9:0]         index_i = 0;
  logic signed [31:0] coord_0_i = 0, coord_1_i = 0, coord_2_i = 0;
  logic               done_o;
  logic [9:0]         vertex_o;
  logic signed [31:0] flow_0_o, flow_1_o, flow_2_o;
  logic               degenerate_o, saturated_o;
  logic               psel = 0, penable = 0, pwrite = 0;
  logic [2:0]         paddr = 0;
  logic [31:0]        pwdata = 0;
  logic [31:0]        prdata;
  logic               pready;

  flow_scoreboard sb = new();
  bit             loaded [1024];
  int             burst_left = 0;
  int             items_sent = 0;

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  closed_curve_shortening_flow_rhs u_top (.*);

  always @(posedge clk_i) begin
    flow_res_t r;
    if (rst_ni && done_o) begin
      r.vertex = vertex_o;
      r.flow[0] = flow_0_o;
      r.flow[1] = flow_1_o;
      r.flow[2] = flow_2_o;
      r.degen = degenerate_o;
      r.sat = saturated_o;
      sb.check_result(r);
    end
  end

  initial begin
    #30ms;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_item(logic req, logic [9:0] idx, logic signed [31:0] c [3]);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    start_i <= 1;
    req_type_i <= req;
    index_i <= idx;
    coord_0_i <= c[0];
    coord_1_i <= c[1];
    coord_2_i <= c[2];
    do @(posedge clk_i); while (busy_o);
    sb.note_item(req, idx, c);
    if (req == REQ_LOAD) loaded[idx] = 1;
    burst_left--;
    items_sent++;
  endtask

  task automatic load_pt(int idx, int x, int y, int z);
    logic signed [31:0] c [3];
    c = '{x, y, z};
    send_item(REQ_LOAD, idx, c);
  endtask

  task automatic query_pt(int idx);
    logic signed [31:0] c [3];
    c = '{$urandom, $urandom, $urandom};
    send_item(REQ_QUERY, idx, c);
  endtask

  // hold until the block has gone quiet
  task automatic drain();
    int guard;
    start_i <= 0;
    burst_left = 0;
    guard = 0;
    while (sb.pending_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (600) @(posedge clk_i);
  endtask

  task automatic apb_write(logic addr_bit, logic [31:0] data);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {addr_bit, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    sb.write_reg({addr_bit, 2'b00}, data);
    @(posedge clk_i);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: case ($urandom_range(0, 3))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 0;
           default: return -1;
         endcase
      2: return int'($urandom_range(0, 6)) - 3;
      default: return int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
    endcase
  endfunction

  function automatic bit can_query(int idx);
    int n;
    n = sb.eff_points();
    if (idx >= n) return 1;
    return loaded[idx] && loaded[(idx == 0) ? n - 1 : idx - 1] && loaded[(idx + 1) % n];
  endfunction

  task automatic rand_load(int idx);
    int src;
    if ($urandom_range(0, 9) == 0) begin
      // copy the next address (the next neighbor except at the wrap) to force a zero edge
      src = (idx + 1) % 1024;
      load_pt(idx, int'(sb.pts[src][0]), int'(sb.pts[src][1]), int'(sb.pts[src][2]));
    end else begin
      load_pt(idx, rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    int n, idx, base, q;
    logic [31:0] nv;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // reset config: wrap across the top of the store
    load_pt(1023, 32'h0001_0000, 0, 0);
    load_pt(0, 0, 32'h0001_0000, 0);
    load_pt(1, -32'sh0001_0000, 0, 32'h1234_5678);
    query_pt(0);
    drain();

    apb_write(REG_POINT_COUNT, 32'd4);
    apb_write(REG_DIMENSION, 32'd3);
    load_pt(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    load_pt(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    load_pt(2, 0, 0, 0);
    load_pt(3, 1, 0, 0);
    load_pt(700, 5, 6, 7);
    for (int i = 0; i < 4; i++) query_pt(i);
    query_pt(4);
    query_pt(1023);
    load_pt(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    query_pt(1);
    query_pt(2);
    // unit square: tiny edges, sharp turn, clips
    load_pt(0, 0, 0, 0);
    load_pt(1, 1, 0, 0);
    load_pt(2, 1, 1, 0);
    load_pt(3, 0, 1, 0);
    query_pt(1);
    query_pt(3);
    drain();

    while (items_sent < 850) begin
      case ($urandom_range(0, 9))
        0: nv = $urandom_range(0, 3);
        1: nv = 1024 + $urandom_range(0, 1023);
        2: nv = 1024;
        default: nv = $urandom_range(4, 12);
      endcase
      apb_write(REG_POINT_COUNT, {$urandom, 11'b0} | nv);
      apb_write(REG_DIMENSION, {$urandom, 2'b0} | $urandom_range(0, 3));
      n = sb.eff_points();
      if (n <= 16) begin
        for (int i = 0; i < n; i++) rand_load(i);
      end else begin
        base = $urandom_range(0, 1023);
        for (int i = -1; i <= 1; i++) rand_load((base + i + n) % n);
        for (int i = 1021; i <= 1025; i++) rand_load(i % n);
      end
      repeat (40) begin
        q = $urandom_range(0, 99);
        if (q < 60) begin
          idx = (n <= 16) ? $urandom_range(0, n - 1) : $urandom_range(0, 1023);
          if (!can_query(idx)) idx = (n <= 16) ? 0 : base;
          query_pt(idx);
        end else if (q < 85) begin
          idx = (n <= 16) ? $urandom_range(0, n - 1) : (base + $urandom_range(0, 2) + n - 1) % n;
          rand_load(idx);
        end else if (q < 93 && n < 1024) begin
          query_pt($urandom_range(n, 1023));
        end else begin
          idx = $urandom_range(0, 1023);
          rand_load(idx);
        end
      end
      drain();
    end

    drain();
    if (sb.pending_q.size() != 0) sb.failed = 1;
    if (!sb.failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
